// ----- rtl/bad_pkg.sv -----
// ----------------------------------------------------------------------------
// bad_pkg: shared types and constants of the box average downscaler
// Sizes, register codes, the state machine type and the reciprocal table
// that turns a division by the scale factor into a multiplication.
// ----------------------------------------------------------------------------
package bad_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS  = 12;
   localparam int HEIGHT_BITS = 16;
   localparam int FACTOR_BITS = 6;
   localparam int PIX_BITS    = 24;
   localparam int RECIP_BITS  = 17;
   localparam int RECIP_SHIFT = 16;
   localparam int STEP_W      = $clog2(WIDTH_BITS);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WIDTH_BITS - 1);

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_SCALE_FACTOR = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_VERT,
      ST_HORZ,
      ST_ACC
   } state_type;

   typedef struct packed {
      logic                  busy;
      logic [WIDTH_BITS-1:0] limit;
   } lim_status_type;

   // ceil(2^16 / f); a factor of zero acts as one
   localparam logic [RECIP_BITS-1:0] RECIP [64] = '{
      17'(65536),        17'(65535/1+1),   17'(65535/2+1),   17'(65535/3+1),
      17'(65535/4+1),    17'(65535/5+1),   17'(65535/6+1),   17'(65535/7+1),
      17'(65535/8+1),    17'(65535/9+1),   17'(65535/10+1),  17'(65535/11+1),
      17'(65535/12+1),   17'(65535/13+1),  17'(65535/14+1),  17'(65535/15+1),
      17'(65535/16+1),   17'(65535/17+1),  17'(65535/18+1),  17'(65535/19+1),
      17'(65535/20+1),   17'(65535/21+1),  17'(65535/22+1),  17'(65535/23+1),
      17'(65535/24+1),   17'(65535/25+1),  17'(65535/26+1),  17'(65535/27+1),
      17'(65535/28+1),   17'(65535/29+1),  17'(65535/30+1),  17'(65535/31+1),
      17'(65535/32+1),   17'(65535/33+1),  17'(65535/34+1),  17'(65535/35+1),
      17'(65535/36+1),   17'(65535/37+1),  17'(65535/38+1),  17'(65535/39+1),
      17'(65535/40+1),   17'(65535/41+1),  17'(65535/42+1),  17'(65535/43+1),
      17'(65535/44+1),   17'(65535/45+1),  17'(65535/46+1),  17'(65535/47+1),
      17'(65535/48+1),   17'(65535/49+1),  17'(65535/50+1),  17'(65535/51+1),
      17'(65535/52+1),   17'(65535/53+1),  17'(65535/54+1),  17'(65535/55+1),
      17'(65535/56+1),   17'(65535/57+1),  17'(65535/58+1),  17'(65535/59+1),
      17'(65535/60+1),   17'(65535/61+1),  17'(65535/62+1),  17'(65535/63+1)
   };

endpackage

// ----- rtl/bad_scale.sv -----
// ----------------------------------------------------------------------------
// bad_scale: per-channel division by the scale factor
// Multiplies each 8-bit channel by the factor's reciprocal and keeps the
// integer part, which equals the truncated quotient for all 8-bit inputs.
// ----------------------------------------------------------------------------
module bad_scale (
   input  logic [23:0] data,    // blue [7:0], green [15:8], red [23:16]
   input  logic [16:0] recip,
   output logic [23:0] quot     // same channel order as data
);
   import bad_pkg::*;

   logic [24:0] prod [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod[c] = 25'(data[8*c +: 8]) * 25'(recip);
         quot[8*c +: 8] = prod[c][RECIP_SHIFT +: 8];
      end
   end

endmodule

// ----- rtl/bad_limit.sv -----
// ----------------------------------------------------------------------------
// bad_limit: last usable column bound
// Restoring remainder, one width bit per cycle, giving
// width - (width mod factor) after every configuration write.
// ----------------------------------------------------------------------------
module bad_limit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [11:0]                    width,
   input  logic [5:0]                     factor,
   output bad_pkg::lim_status_type        status
);
   import bad_pkg::*;

   logic                   busy_ff, busy_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [FACTOR_BITS-1:0] rem_ff, rem_in;
   logic [WIDTH_BITS-1:0]  limit_ff, limit_in;
   logic [FACTOR_BITS:0]   shifted;
   logic [FACTOR_BITS-1:0] rem_next;
   logic [STEP_W-1:0]      bit_sel;

   always_comb begin
      bit_sel = LAST_STEP - step_ff;
      shifted = {rem_ff, width[bit_sel]};
      if (shifted >= {1'b0, factor}) begin
         rem_next = FACTOR_BITS'(shifted - {1'b0, factor});
      end else begin
         rem_next = FACTOR_BITS'(shifted);
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      limit_in = limit_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = rem_next;
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in  = 1'b0;
            limit_in = width - WIDTH_BITS'(rem_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= '0;
         rem_ff   <= '0;
         limit_ff <= WIDTH_BITS'(1);
      end else begin
         busy_ff  <= busy_in;
         step_ff  <= step_in;
         rem_ff   <= rem_in;
         limit_ff <= limit_in;
      end
   end

   assign status.busy  = busy_ff;
   assign status.limit = limit_ff;

endmodule

// ----- rtl/box_average_downscale.sv -----
// ----------------------------------------------------------------------------
// box_average_downscale: integer-factor box filter for a raster RGB stream
// Vertical sums per column live in a line store; horizontal sums are
// accumulated on the last row of each row group and emitted per block.
// ----------------------------------------------------------------------------
// Each accepted pixel steps through the states: address the line store, read
// and write back the column sum, divide it by the factor, then accumulate and
// advance the counters, before the next pixel is taken. The line store's
// single read-modify-write per pixel sets that order; the last state waits on
// an untaken result. After any configuration write the block holds req_tready
// low while it derives the last usable column from width and factor.
module box_average_downscale (
   input  logic        clock,
   input  logic        reset,
   // pixel input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pix_blue [7:0], pix_green [15:8], pix_red [23:16]
   // averaged output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_blue [7:0], out_green [15:8], out_red [23:16]
   output logic        rsp_tlast,   // row_end
   output logic [0:0]  rsp_tuser,   // frame_end [0]
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bad_pkg::*;

   function automatic logic [23:0] add_bytes(input logic [23:0] a, input logic [23:0] b);
      logic [23:0] r;
      for (int c = 0; c < 3; c++) begin
         r[8*c +: 8] = a[8*c +: 8] + b[8*c +: 8];
      end
      return r;
   endfunction

   // configuration registers
   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;
   logic [FACTOR_BITS-1:0] factor_ff;
   logic                   csr_wr;
   logic [1:0]             csr_idx;

   logic [WIDTH_BITS-1:0]  w_eff;
   logic [HEIGHT_BITS-1:0] h_eff;
   logic [FACTOR_BITS-1:0] f_eff;
   logic [RECIP_BITS-1:0]  recip;
   lim_status_type         lim;

   // state machine
   state_type state_ff, state_in;
   logic      accept, rd_en, wr_en, commit, out_blocked;

   // datapath registers
   logic [COL_W-1:0]       col_ff, col_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;
   logic [FACTOR_BITS-1:0] rig_ff, rig_in;
   logic [FACTOR_BITS-1:0] cig_ff, cig_in;
   logic [PIX_BITS-1:0]    row_sum_ff, row_sum_in;
   logic [PIX_BITS-1:0]    qpix_ff, qpix_d;
   logic [PIX_BITS-1:0]    rd_ff;
   logic [PIX_BITS-1:0]    vsum_ff, vsum_in;
   logic [PIX_BITS-1:0]    qv_ff, qv_d;
   logic [PIX_BITS-1:0]    hsum;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PIX_BITS-1:0]    rsp_data_ff;
   logic                   rsp_last_ff, rsp_frame_ff;

   logic                   horz_en, out_en, row_end, frame_end;

   logic [PIX_BITS-1:0]    line_store [MAX_WIDTH];

   // ------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_BITS'(1);
         height_ff <= HEIGHT_BITS'(1);
         factor_ff <= FACTOR_BITS'(1);
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[WIDTH_BITS-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[HEIGHT_BITS-1:0];
            REG_SCALE_FACTOR: factor_ff <= csr_pwdata[FACTOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_IMAGE_WIDTH:  csr_prdata = 32'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = 32'(height_ff);
         REG_SCALE_FACTOR: csr_prdata = 32'(factor_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // zero acts as one; width is clamped to the line store
   always_comb begin
      f_eff = (factor_ff == '0) ? FACTOR_BITS'(1) : factor_ff;
      h_eff = (height_ff == '0) ? HEIGHT_BITS'(1) : height_ff;
      if (width_ff == '0) begin
         w_eff = WIDTH_BITS'(1);
      end else if (width_ff > WIDTH_BITS'(MAX_WIDTH)) begin
         w_eff = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      recip = RECIP[factor_ff];
   end

   bad_limit u_limit (
      .clock  (clock),
      .reset  (reset),
      .start  (csr_wr),
      .width  (w_eff),
      .factor (f_eff),
      .status (lim)
   );

   bad_scale u_scale_pix (
      .data  (req_tdata),
      .recip (recip),
      .quot  (qpix_d)
   );

   bad_scale u_scale_col (
      .data  (vsum_ff),
      .recip (recip),
      .quot  (qv_d)
   );

   // ------------------------------------------------------------------
   // group decisions for the current pixel
   // ------------------------------------------------------------------
   always_comb begin
      horz_en   = ((7'(rig_ff) + 7'd1) >= 7'(f_eff)) &&
                  (WIDTH_BITS'(col_ff) < lim.limit);
      out_en    = horz_en && ((7'(cig_ff) + 7'd1) >= 7'(f_eff));
      row_end   = (13'(col_ff) + 13'd1 + 13'(f_eff)) > 13'(w_eff);
      frame_end = row_end &&
                  ((17'(row_ff) + 17'd1 + 17'(f_eff)) > 17'(h_eff));
      out_blocked = out_en && rsp_valid_ff && !rsp_tready;
      hsum      = add_bytes((cig_ff == '0) ? '0 : row_sum_ff, qv_ff);
   end

   // ------------------------------------------------------------------
   // state machine
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_VERT;
         ST_VERT: state_in = ST_HORZ;
         ST_HORZ: state_in = ST_ACC;
         ST_ACC:  if (!out_blocked) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      commit     = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = !lim.busy && !csr_wr;
         ST_VERT: wr_en = 1'b1;
         ST_HORZ: ;
         ST_ACC:  commit = !out_blocked;
         default: ;
      endcase
      accept = req_tvalid && req_tready;
      rd_en  = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------
   // line store: read on accept in ST_IDLE, written back in ST_VERT later
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_store[col_ff] <= vsum_in;
      end
      if (rd_en) begin
         rd_ff <= line_store[col_ff];
      end
   end

   always_comb begin
      vsum_in = add_bytes((rig_ff == '0) ? '0 : rd_ff, qpix_ff);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         qpix_ff <= qpix_d;
      end
      if (wr_en) begin
         vsum_ff <= vsum_in;
      end
      if (state_ff == ST_HORZ) begin
         qv_ff <= qv_d;
      end
   end

   // ------------------------------------------------------------------
   // horizontal accumulation and counter advance
   // ------------------------------------------------------------------
   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      rig_in     = rig_ff;
      cig_in     = cig_ff;
      row_sum_in = row_sum_ff;
      if (commit) begin
         if (horz_en) begin
            row_sum_in = hsum;
            cig_in     = out_en ? '0 : cig_ff + 1'b1;
         end
         if ((12'(col_ff) + 12'd1) >= w_eff) begin
            col_in     = '0;
            cig_in     = '0;
            row_sum_in = '0;
            if ((17'(row_ff) + 17'd1) >= 17'(h_eff)) begin
               row_in = '0;
               rig_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
               rig_in = ((7'(rig_ff) + 7'd1) >= 7'(f_eff)) ? '0 : rig_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         rig_ff     <= '0;
         cig_ff     <= '0;
         row_sum_ff <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         rig_ff     <= rig_in;
         cig_ff     <= cig_in;
         row_sum_ff <= row_sum_in;
      end
   end

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (commit && out_en) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // take the block sum before the row wrap clears the accumulator
   always_ff @(posedge clock) begin
      if (commit && out_en) begin
         rsp_data_ff  <= hsum;
         rsp_last_ff  <= row_end;
         rsp_frame_ff <= frame_end;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_frame_ff;

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: box average downscaler testbench
// Streams RGB pixels under several frame geometries and downscale factors,
// predicts every averaged block with a cycle-free model of the two-pass box
// filter, and compares each output transaction field by field. Register
// writes are read back over the APB port.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bad_pkg::*;

   typedef struct {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       row_end;
      logic       frame_end;
   } block_avg_type;

   class downscale_scoreboard;
      logic [11:0]   width_reg;
      logic [15:0]   height_reg;
      logic [5:0]    factor_reg;
      logic [23:0]   col_sum [MAX_WIDTH];
      logic [23:0]   row_acc;
      int unsigned   col_idx, row_idx, row_grp, col_grp;
      block_avg_type pending_blocks [$];
      int unsigned   failures;

      function new();
         width_reg  = 12'd1;
         height_reg = 16'd1;
         factor_reg = 6'd1;
         foreach (col_sum[i]) col_sum[i] = '0;
         row_acc  = '0;
         col_idx  = 0;
         row_idx  = 0;
         row_grp  = 0;
         col_grp  = 0;
         failures = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_IMAGE_WIDTH:  width_reg  = value[11:0];
            REG_IMAGE_HEIGHT: height_reg = value[15:0];
            REG_SCALE_FACTOR: factor_reg = value[5:0];
            default: ;
         endcase
      endfunction

      function int unsigned eff_width();
         int unsigned w;
         w = (width_reg == 0) ? 1 : width_reg;
         return (w > MAX_WIDTH) ? MAX_WIDTH : w;
      endfunction

      function bit at_group_start();
         return col_idx == 0 && row_grp == 0;
      endfunction

      function int pending();
         return pending_blocks.size();
      endfunction

      // per channel: acc + x/f, each channel wrapping at 8 bits
      function logic [23:0] scaled_add(logic [23:0] acc, logic [23:0] x, int unsigned f);
         logic [23:0] r;
         for (int c = 0; c < 3; c++)
            r[8*c +: 8] = 8'(int'(acc[8*c +: 8]) + int'(x[8*c +: 8]) / f);
         return r;
      endfunction

      function void note_pixel(logic [23:0] px);
         int unsigned   f, w, h, col;
         logic [23:0]   vsum;
         block_avg_type blk;
         f   = (factor_reg == 0) ? 1 : factor_reg;
         h   = (height_reg == 0) ? 1 : height_reg;
         w   = eff_width();
         col = (col_idx < MAX_WIDTH) ? col_idx : 0;

         vsum = scaled_add((row_grp == 0) ? 24'h0 : col_sum[col], px, f);
         col_sum[col] = vsum;

         if (row_grp + 1 >= f && col_idx < (w / f) * f) begin
            row_acc = scaled_add((col_grp == 0) ? 24'h0 : row_acc, vsum, f);
            if (col_grp + 1 >= f) begin
               blk.blue      = row_acc[7:0];
               blk.green     = row_acc[15:8];
               blk.red       = row_acc[23:16];
               blk.row_end   = (col_idx + 1 + f > w);
               blk.frame_end = blk.row_end && (row_idx + 1 + f > h);
               pending_blocks.push_back(blk);
               col_grp = 0;
            end else begin
               col_grp++;
            end
         end

         if (col_idx + 1 >= w) begin
            col_idx = 0;
            col_grp = 0;
            row_acc = '0;
            if (row_idx + 1 >= h) begin
               row_idx = 0;
               row_grp = 0;
            end else begin
               row_idx++;
               row_grp = (row_grp + 1 >= f) ? 0 : row_grp + 1;
            end
         end else begin
            col_idx++;
         end
      endfunction

      function void compare(string name, int unsigned exp_val, int unsigned act_val);
         if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            failures++;
         end
      endfunction

      function void check_block(logic [23:0] data, logic last, logic frame_flag);
         block_avg_type blk;
         if (pending_blocks.size() == 0) begin
            $error("output transaction with nothing expected: data %06h", data);
            failures++;
            return;
         end
         blk = pending_blocks.pop_front();
         compare("out_blue", blk.blue, data[7:0]);
         compare("out_green", blk.green, data[15:8]);
         compare("out_red", blk.red, data[23:16]);
         compare("row_end", blk.row_end, last);
         compare("frame_end", blk.frame_end, frame_flag);
      endfunction
   endclass

   localparam int RANDOM_ITEMS  = 1400;
   localparam int SETTLE_CYCLES = 16;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   downscale_scoreboard sb;
   int unsigned src_gap_pct;
   int unsigned sink_stall_pct;

   box_average_downscale dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb: errors");
      $finish;
   end

   // result sink: random backpressure, check on every transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_block(rsp_tdata, rsp_tlast, rsp_tuser[0]);
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   task automatic send_pixel(input logic [23:0] px);
      while ($urandom_range(99) < src_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(px);
   endtask

   function automatic logic [23:0] rand_pixel();
      logic [23:0] px;
      px = 24'($urandom);
      for (int c = 0; c < 3; c++)
         case ($urandom_range(15))
            0: px[8*c +: 8] = 8'h00;
            1: px[8*c +: 8] = 8'hFF;
            default: ;
         endcase
      return px;
   endfunction

   task automatic send_random(input int unsigned count);
      repeat (count) send_pixel(rand_pixel());
   endtask

   // drop valid, wait for every predicted block, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] mask;
      case (idx)
         REG_IMAGE_WIDTH:  mask = 32'h0000_0FFF;
         REG_IMAGE_HEIGHT: mask = 32'h0000_FFFF;
         default:          mask = 32'h0000_003F;
      endcase
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
      // read back the same register
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== (value & mask)) begin
         $error("csr readback %0d: expected %0h, got %0h", idx, value & mask, csr_prdata);
         sb.failures++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h,
                               input int unsigned f);
      write_csr(REG_IMAGE_WIDTH, w);
      write_csr(REG_IMAGE_HEIGHT, h);
      write_csr(REG_SCALE_FACTOR, f);
   endtask

   initial begin
      int unsigned random_items;
      int unsigned f, w, h, n, we, he;

      sb             = new();
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      src_gap_pct    = 36;
      sink_stall_pct = 45;
      random_items   = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // reset geometry: each pixel in gives one pixel out, both end flags set
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h5AA55A);
      settle();

      // 2x2 blocks on a 4x2 frame, truncation in both passes
      set_geometry(4, 2, 2);
      send_pixel(24'hFFFFFF);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h010101);
      send_pixel(24'h7F7F7F);
      send_pixel(24'hFFFFFF);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
      send_pixel(24'h030303);
      settle();

      // zero registers act as one
      set_geometry(0, 0, 0);
      send_pixel(24'h123456);
      send_pixel(24'hEDCBA9);
      settle();

      // factor larger than the frame: no output, counters still wrap
      set_geometry(3, 2, 63);
      send_random(6);
      settle();

      // tallest frame, then a height change mid-frame that the row count has passed
      set_geometry(2, 65535, 2);
      send_random(8);
      settle();
      write_csr(REG_IMAGE_HEIGHT, 2);
      send_random(2);
      settle();

      // large factor: one block, last column dropped
      set_geometry(17, 16, 16);
      send_random(17 * 16);
      settle();

      while (random_items < RANDOM_ITEMS) begin
         if (random_items < RANDOM_ITEMS / 3) begin
            src_gap_pct    = 36;
            sink_stall_pct = 45;
         end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
            src_gap_pct    = 45;
            sink_stall_pct = 36;
         end else begin
            src_gap_pct    = 0;
            sink_stall_pct = 0;
         end

         f = ($urandom_range(9) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 4);
         // change the width only where no column sum of the old row is still needed
         if (sb.at_group_start())
            w = ($urandom_range(7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 20);
         else
            w = sb.width_reg;
         h  = $urandom_range(0, 3 * ((f == 0) ? 1 : f) + 2);
         set_geometry(w, h, f);

         we = sb.eff_width();
         he = (h == 0) ? 1 : h;
         n  = we * he;
         if ($urandom_range(3) == 0)
            n = $urandom_range(1, n);
         if (n > RANDOM_ITEMS - random_items)
            n = RANDOM_ITEMS - random_items;
         send_random(n);
         random_items += n;
         settle();
      end

      // width beyond the line store: a partial row at the clamped width
      set_geometry(4095, 1, 1);
      send_random(100);
      settle();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
